### src/alids_pkg.sv
// Shared types and constants for the array list block.
// Used by the top level; no dependencies.
package alids_pkg;

	localparam int DEPTH        = 32;
	localparam int IDX_W        = $clog2(DEPTH);
	localparam int CNT_W        = $clog2(DEPTH + 1);
	localparam int CMP_W        = (CNT_W > 5) ? CNT_W : 5;
	localparam int WORD_W       = 32;
	localparam int RESULT_LIMIT = 32;

	typedef enum logic [1:0] {
		CMD_INSERT   = 2'd0,
		CMD_DELETE   = 2'd1,
		CMD_SEARCH   = 2'd2,
		CMD_TRAVERSE = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_NOT_FOUND = 3'd1,
		ST_BAD_POS   = 3'd2,
		ST_FULL      = 3'd3,
		ST_EMPTY     = 3'd4
	} status_t;

	typedef struct packed {
		cmd_t               command;
		logic [4:0]         position;
		logic signed [31:0] value;
	} request_t;

	typedef struct packed {
		status_t            status;
		logic [4:0]         found_index;
		logic signed [31:0] entry_value;
		logic [5:0]         entry_count;
		logic               last;
	} result_t;

endpackage

### src/alids_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module alids_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

### src/array_list_insert_delete_search.sv
// Array list top level: insert, delete, linear search and traverse over one RAM.
// Errors, insert at the tail and delete of the tail give their result in the cycle
// after the transfer; insert at p moves entries p..n-1 up one slot, then writes at p;
// delete at p moves entries p+1..n-1 down one; search scans from index 0 to a match.
// Traverse gives one entry per cycle; all steps share the single RAM read/write port pair.
// Reset clears the count and the controller; stored entries are not cleared.
module array_list_insert_delete_search (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  alids_pkg::request_t request,
	output logic               result_valid,
	output alids_pkg::result_t  result
);
	import alids_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS,       // shift entries up, walking down from the tail
		S_INS_FIN,   // drop the new value into the freed slot
		S_DEL,       // shift entries down, walking up from the deleted slot
		S_SRCH,      // compare one entry per cycle
		S_TRAV       // emit one entry per cycle
	} state_t;

	state_t              state_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [IDX_W-1:0]    pos_q;
	logic [IDX_W-1:0]    di_q;      // index of the entry arriving on the RAM read port
	logic [WORD_W-1:0]   val_q;
	result_t             result_q;
	logic                result_valid_q;

	logic                ram_we;
	logic [IDX_W-1:0]    ram_waddr;
	logic [WORD_W-1:0]   ram_wdata;
	logic [IDX_W-1:0]    ram_raddr;
	logic [WORD_W-1:0]   ram_rdata;

	logic                accept;
	logic [CMP_W-1:0]    req_pos;
	logic [CMP_W-1:0]    cnt_x;
	logic                ins_bad, full, ins_tail;
	logic                del_empty, del_bad, del_tail;
	logic [CNT_W-1:0]    di_next;
	logic                scan_end;
	logic                trav_last;

	function automatic result_t mk_result(status_t st, logic [IDX_W-1:0] idx,
			logic [WORD_W-1:0] v, logic [CNT_W-1:0] c, logic l);
		result_t r;
		r.status      = st;
		r.found_index = 5'(idx);
		r.entry_value = v;
		r.entry_count = 6'(c);
		r.last        = l;
		return r;
	endfunction

	// a transfer is taken only while the controller is idle
	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;

	// position checks against the count, both widened so no bit of the request is lost
	assign req_pos   = CMP_W'(request.position);
	assign cnt_x     = CMP_W'(cnt_q);
	assign ins_bad   = (req_pos > cnt_x);
	assign full      = (cnt_q == CNT_W'(DEPTH));
	assign ins_tail  = (req_pos == cnt_x);
	assign del_empty = (cnt_q == '0);
	assign del_bad   = (req_pos >= cnt_x);
	assign del_tail  = (req_pos + CMP_W'(1) == cnt_x);

	// next index of a forward scan, and whether the arriving entry is the last stored one
	assign di_next   = CNT_W'(di_q) + CNT_W'(1);
	assign scan_end  = (di_next == cnt_q);
	assign trav_last = scan_end || (int'(di_q) + 1 == RESULT_LIMIT);

	// RAM port control. Reads run one step ahead of writes; in a shift the read and
	// write addresses are two apart and move the same way, so they never collide.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = di_q;
		ram_wdata = val_q;
		ram_raddr = di_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (request.command)
						CMD_INSERT: begin
							if (ins_tail) begin
								// appending needs no shift: write straight in
								ram_we    = !ins_bad && !full;
								ram_waddr = IDX_W'(request.position);
								ram_wdata = request.value;
							end else begin
								ram_raddr = IDX_W'(cnt_q - CNT_W'(1));
							end
						end
						CMD_DELETE: ram_raddr = IDX_W'(request.position) + IDX_W'(1);
						CMD_SEARCH, CMD_TRAVERSE: ram_raddr = '0;
						default: ram_raddr = '0;
					endcase
				end
			end
			S_INS: begin
				ram_we    = 1'b1;
				ram_waddr = di_q + IDX_W'(1);
				ram_wdata = ram_rdata;
				ram_raddr = di_q - IDX_W'(1);
			end
			S_INS_FIN: begin
				ram_we    = 1'b1;
				ram_waddr = pos_q;
				ram_wdata = val_q;
			end
			S_DEL: begin
				ram_we    = 1'b1;
				ram_waddr = di_q - IDX_W'(1);
				ram_wdata = ram_rdata;
				ram_raddr = di_q + IDX_W'(1);
			end
			S_SRCH, S_TRAV: ram_raddr = di_q + IDX_W'(1);
			default: ram_raddr = di_q;
		endcase
	end

	alids_ram #(
		.WIDTH(WORD_W),
		.DEPTH(DEPTH)
	) u_entries (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// controller: state, count, scan index and the registered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			cnt_q          <= '0;
			pos_q          <= '0;
			di_q           <= '0;
			val_q          <= '0;
			result_q       <= '0;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						pos_q <= IDX_W'(request.position);
						val_q <= request.value;
						unique case (request.command)
							CMD_INSERT: begin
								// bad position is checked before fullness
								if (ins_bad) begin
									result_q       <= mk_result(ST_BAD_POS, '0, '0, cnt_q, 1'b1);
									result_valid_q <= 1'b1;
								end else if (full) begin
									result_q       <= mk_result(ST_FULL, '0, '0, cnt_q, 1'b1);
									result_valid_q <= 1'b1;
								end else if (ins_tail) begin
									cnt_q          <= cnt_q + CNT_W'(1);
									result_q       <= mk_result(ST_OK, '0, '0,
											cnt_q + CNT_W'(1), 1'b1);
									result_valid_q <= 1'b1;
								end else begin
									di_q    <= IDX_W'(cnt_q - CNT_W'(1));
									state_q <= S_INS;
								end
							end
							CMD_DELETE: begin
								if (del_empty) begin
									result_q       <= mk_result(ST_EMPTY, '0, '0, cnt_q, 1'b1);
									result_valid_q <= 1'b1;
								end else if (del_bad) begin
									result_q       <= mk_result(ST_BAD_POS, '0, '0, cnt_q, 1'b1);
									result_valid_q <= 1'b1;
								end else if (del_tail) begin
									// removing the tail moves nothing
									cnt_q          <= cnt_q - CNT_W'(1);
									result_q       <= mk_result(ST_OK, '0, '0,
											cnt_q - CNT_W'(1), 1'b1);
									result_valid_q <= 1'b1;
								end else begin
									di_q    <= IDX_W'(request.position) + IDX_W'(1);
									state_q <= S_DEL;
								end
							end
							CMD_SEARCH: begin
								if (del_empty) begin
									result_q       <= mk_result(ST_NOT_FOUND, '0, '0,
											cnt_q, 1'b1);
									result_valid_q <= 1'b1;
								end else begin
									di_q    <= '0;
									state_q <= S_SRCH;
								end
							end
							CMD_TRAVERSE: begin
								if (del_empty) begin
									result_q       <= mk_result(ST_EMPTY, '0, '0, cnt_q, 1'b1);
									result_valid_q <= 1'b1;
								end else begin
									di_q    <= '0;
									state_q <= S_TRAV;
								end
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_INS: begin
					if (di_q == pos_q) begin
						state_q <= S_INS_FIN;
					end else begin
						di_q <= di_q - IDX_W'(1);
					end
				end
				S_INS_FIN: begin
					cnt_q          <= cnt_q + CNT_W'(1);
					result_q       <= mk_result(ST_OK, '0, '0, cnt_q + CNT_W'(1), 1'b1);
					result_valid_q <= 1'b1;
					state_q        <= S_IDLE;
				end
				S_DEL: begin
					if (scan_end) begin
						cnt_q          <= cnt_q - CNT_W'(1);
						result_q       <= mk_result(ST_OK, '0, '0, cnt_q - CNT_W'(1), 1'b1);
						result_valid_q <= 1'b1;
						state_q        <= S_IDLE;
					end else begin
						di_q <= IDX_W'(di_next);
					end
				end
				S_SRCH: begin
					// first match wins
					if (ram_rdata == val_q) begin
						result_q       <= mk_result(ST_OK, di_q, '0, cnt_q, 1'b1);
						result_valid_q <= 1'b1;
						state_q        <= S_IDLE;
					end else if (scan_end) begin
						result_q       <= mk_result(ST_NOT_FOUND, '0, '0, cnt_q, 1'b1);
						result_valid_q <= 1'b1;
						state_q        <= S_IDLE;
					end else begin
						di_q <= IDX_W'(di_next);
					end
				end
				S_TRAV: begin
					result_q       <= mk_result(ST_OK, di_q, ram_rdata, cnt_q, trav_last);
					result_valid_q <= 1'b1;
					if (trav_last) begin
						state_q <= S_IDLE;
					end else begin
						di_q <= IDX_W'(di_next);
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign result       = result_q;
	assign result_valid = result_valid_q;

`ifndef ASSERT_OFF
	// the count never passes the capacity
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("entry count above capacity");

	// a final result always coincides with the controller going idle
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.last |-> !busy)
		else $error("final result while still busy");

	// intermediate results only come from a running traverse
	a_mid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.last |-> busy && $past(state_q) == S_TRAV)
		else $error("intermediate result outside a traverse");

	// delete shift stays inside the stored range and never writes below slot zero
	a_del_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DEL |-> di_q != '0 && CNT_W'(di_q) < cnt_q)
		else $error("delete shift index out of range");

	// insert shift never walks below the insert position
	a_ins_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_INS |-> di_q >= pos_q && CNT_W'(di_q) < cnt_q)
		else $error("insert shift index out of range");
`endif

endmodule

### test/array_list_checker.sv
// Checker for the array list block: watches the command and result channels,
// keeps its own copy of the list and compares every result in order.
// Depends on alids_pkg for the request and result types.
module array_list_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  alids_pkg::request_t request,
	input  logic               result_valid,
	input  alids_pkg::result_t  result,
	output int                 mismatches,
	output int                 outstanding,
	output int                 list_length
);
	timeunit 1ns;
	timeprecision 1ps;
	import alids_pkg::*;

	logic signed [31:0] list_words [DEPTH];
	int                 list_len;
	result_t            expected_results [$];

	// Model one accepted command and queue every result it should produce.
	task automatic apply_command(input request_t req);
		result_t r;
		int      i;
		int      n;
		int      hit;
		int      emit;
		n = list_len;
		r = '0;
		r.last = 1'b1;
		case (req.command)
			CMD_INSERT: begin
				if (req.position > n) begin
					r.status = ST_BAD_POS;
				end else if (n >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					for (i = n; i > req.position; i--)
						list_words[i] = list_words[i - 1];
					list_words[req.position] = req.value;
					list_len = n + 1;
					r.status = ST_OK;
				end
				r.entry_count = 6'(list_len);
				expected_results.push_back(r);
			end
			CMD_DELETE: begin
				if (n == 0) begin
					r.status = ST_EMPTY;
				end else if (req.position >= n) begin
					r.status = ST_BAD_POS;
				end else begin
					for (i = req.position; i + 1 < n; i++)
						list_words[i] = list_words[i + 1];
					list_len = n - 1;
					r.status = ST_OK;
				end
				r.entry_count = 6'(list_len);
				expected_results.push_back(r);
			end
			CMD_SEARCH: begin
				hit = -1;
				for (i = 0; i < n; i++)
					if (hit < 0 && list_words[i] == req.value)
						hit = i;
				r.status      = (hit < 0) ? ST_NOT_FOUND : ST_OK;
				r.found_index = (hit < 0) ? 5'd0 : 5'(hit);
				r.entry_count = 6'(n);
				expected_results.push_back(r);
			end
			default: begin
				if (n == 0) begin
					r.status = ST_EMPTY;
					expected_results.push_back(r);
				end else begin
					emit = (n < RESULT_LIMIT) ? n : RESULT_LIMIT;
					for (i = 0; i < emit; i++) begin
						r.status      = ST_OK;
						r.found_index = 5'(i);
						r.entry_value = list_words[i];
						r.entry_count = 6'(n);
						r.last        = (i + 1 == emit);
						expected_results.push_back(r);
					end
				end
			end
		endcase
	endtask

	task automatic check_result(input result_t got);
		result_t exp;
		if (expected_results.size() == 0) begin
			$error("result with nothing expected: status %0d index %0d value %0d",
				got.status, got.found_index, got.entry_value);
			mismatches++;
		end else begin
			exp = expected_results.pop_front();
			if (got.status !== exp.status) begin
				$error("status: expected %0d, actual %0d", exp.status, got.status);
				mismatches++;
			end
			if (got.found_index !== exp.found_index) begin
				$error("found_index: expected %0d, actual %0d",
					exp.found_index, got.found_index);
				mismatches++;
			end
			if (got.entry_value !== exp.entry_value) begin
				$error("entry_value: expected %0d, actual %0d",
					exp.entry_value, got.entry_value);
				mismatches++;
			end
			if (got.entry_count !== exp.entry_count) begin
				$error("entry_count: expected %0d, actual %0d",
					exp.entry_count, got.entry_count);
				mismatches++;
			end
			if (got.last !== exp.last) begin
				$error("last: expected %0d, actual %0d", exp.last, got.last);
				mismatches++;
			end
		end
	endtask

	// A result can never belong to a command accepted at the same edge,
	// so results are checked before the new command is modeled.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			list_len = 0;
			expected_results.delete();
		end else begin
			if (result_valid === 1'b1)
				check_result(result);
			if (start && busy === 1'b0)
				apply_command(request);
		end
		outstanding <= expected_results.size();
		list_length <= list_len;
	end

endmodule

### test/array_list_insert_delete_search_tb.sv
// Testbench top for array_list_insert_delete_search: clock, reset, command
// stimulus and the verdict. Depends on alids_pkg, the block and array_list_checker.
module array_list_insert_delete_search_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import alids_pkg::*;

	localparam int RANDOM_ITEMS = 108;
	localparam int STALL_LIMIT  = 3000; // cycles with no transfer on either side
	localparam int DRAIN_CYCLES = 40;   // idle wait for stray results after the last expected one

	logic     clk    = 1'b0;
	logic     arst_n = 1'b0;
	logic     start  = 1'b0;
	request_t request = '0;
	logic     busy;
	logic     result_valid;
	result_t  result;

	int mismatches;
	int outstanding;
	int list_length;
	int burst_left;

	array_list_insert_delete_search dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.request      (request),
		.result_valid (result_valid),
		.result       (result)
	);

	array_list_checker list_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.request      (request),
		.result_valid (result_valid),
		.result       (result),
		.mismatches   (mismatches),
		.outstanding  (outstanding),
		.list_length  (list_length)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Watchdog: a hung block stops both command and result transfers.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((start && busy === 1'b0) || result_valid === 1'b1)
				quiet = 0;
			else
				quiet++;
		end
		$display("array_list_insert_delete_search_tb NOT OK");
		$finish;
	end

	// Present one command and hold it until the transfer happens.
	// Called at a rising edge; returns at the edge that took the command, or after the pacing gap.
	task automatic send(input cmd_t cmd, input int pos, input logic signed [31:0] val);
		request_t req;
		int       gap;
		req.command  = cmd;
		req.position = 5'(pos);
		req.value    = val;
		start   <= 1'b1;
		request <= req;
		do @(posedge clk); while (busy !== 1'b0);
		// Sender pacing: bursts of back-to-back commands, then a gap.
		// Long gaps let the block finish and sit idle; short ones land mid-operation.
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 16)
				: $urandom_range(0, 5);
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40)
				: $urandom_range(1, 4);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Small pool so that searches hit and duplicates exist; otherwise any word.
	function automatic logic signed [31:0] pick_word(input int pool_pct);
		if ($urandom_range(0, 99) < pool_pct)
			return $signed(32'($urandom_range(0, 7))) - 32'sd4;
		return $urandom;
	endfunction

	initial begin
		int   k;
		int   n;
		int   roll;
		int   pos;
		bit   filling;
		cmd_t cmd;

		burst_left = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty-list cases first, then extremes of value and position.
		send(CMD_TRAVERSE, 0, 32'sd0);             // traverse of empty list
		send(CMD_DELETE, 0, 32'sd0);               // delete from empty list
		send(CMD_SEARCH, 0, 32'sd5);               // search of empty list
		send(CMD_INSERT, 1, 32'sd9);               // insert past the end
		send(CMD_INSERT, 0, 32'sh7FFF_FFFF);
		send(CMD_INSERT, 0, 32'sh8000_0000);       // head
		send(CMD_INSERT, 2, -32'sd1);              // tail
		send(CMD_INSERT, 1, 32'sd0);               // middle
		send(CMD_INSERT, 4, 32'sd1);
		send(CMD_SEARCH, 0, -32'sd1);
		send(CMD_SEARCH, 31, 32'sd12345);          // no match
		send(CMD_INSERT, 31, 32'sd7);              // position far past the end
		send(CMD_INSERT, 0, 32'sd0);               // duplicate: search gives first
		send(CMD_SEARCH, 0, 32'sd0);
		send(CMD_DELETE, 6, 32'sd0);               // delete at the count
		send(CMD_DELETE, 31, 32'sd0);
		send(CMD_TRAVERSE, 0, 32'sd0);
		send(CMD_DELETE, 5, 32'sd0);               // tail
		send(CMD_DELETE, 0, 32'sd0);               // head
		send(CMD_DELETE, 1, 32'sd0);               // middle
		send(CMD_TRAVERSE, 0, 32'sd0);

		// Random: alternate fill and drain phases so the list runs between
		// empty and full. list_length trails by one command; that only skews
		// positions slightly and adds a few bad-position cases.
		filling = 1'b1;
		for (k = 0; k < RANDOM_ITEMS; k++) begin
			n = list_length;
			if (filling && n >= DEPTH) begin
				filling = 1'b0;
				send(CMD_TRAVERSE, 0, 32'sd0);     // longest traverse
				send(CMD_INSERT, $urandom_range(0, DEPTH - 1), pick_word(40)); // full
			end else if (!filling && n == 0) begin
				filling = 1'b1;
			end
			roll = $urandom_range(0, 99);
			if (roll < (filling ? 65 : 15))
				cmd = CMD_INSERT;
			else if (roll < (filling ? 75 : 70))
				cmd = CMD_DELETE;
			else if (roll < 90)
				cmd = CMD_SEARCH;
			else
				cmd = CMD_TRAVERSE;
			if ($urandom_range(0, 99) < 15)
				pos = $urandom_range(0, 31);
			else if (cmd == CMD_INSERT)
				pos = $urandom_range(0, (n < 31) ? n : 31);
			else
				pos = $urandom_range(0, (n > 0) ? n - 1 : 0);
			send(cmd, pos, pick_word((cmd == CMD_SEARCH) ? 70 : 40));
		end

		start <= 1'b0;
		// outstanding is updated at the edge that took the last command.
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		// Catch any stray result after the last expected one.
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("array_list_insert_delete_search_tb OK");
		else
			$display("array_list_insert_delete_search_tb NOT OK");
		$finish;
	end

endmodule
